// File: hw/rtl/sgp_pkg.sv
`default_nettype none

package sgp_pkg;

    localparam int GAIN_FB = 16;
    localparam int POS_FB  = 8;

    localparam logic [16:0] GAIN_ONE = 17'(1) << GAIN_FB;
    localparam logic [30:0] Q30_ONE  = 31'(1) << 30;

    // floor(v * 2^16 / 100) == (v * 2^14 * BASE_RECIP) >> 26 for v <= 100
    localparam logic [21:0] BASE_RECIP = 22'd2684355;

    // stage map
    localparam int ST_DIFF = 0;
    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int SQRT_N  = 25;
    localparam int ST_SQRT = 3;
    localparam int ST_DIVI = ST_SQRT + SQRT_N;
    localparam int DIV_N   = 16;
    localparam int ST_DIV  = ST_DIVI + 1;
    localparam int ST_LOGI = ST_DIV + DIV_N;
    localparam int LOG_N   = 16;
    localparam int ST_LOG  = ST_LOGI + 1;
    localparam int ST_LOGF = ST_LOG + LOG_N;
    localparam int ST_POW  = ST_LOGF + 1;
    localparam int EXP_N   = 16;
    localparam int ST_EXP  = ST_POW + 1;
    localparam int ST_PW   = ST_EXP + EXP_N;
    localparam int ST_DG   = ST_PW + 1;
    localparam int ST_GAIN = ST_DG + 1;
    localparam int ST_OUT  = ST_GAIN + 1;
    localparam int N_STAGE = ST_OUT + 1;

    typedef enum logic [2:0] {
        CFG_PRESENT = 3'd0,
        CFG_WANTS   = 3'd1,
        CFG_VOLUME  = 3'd2,
        CFG_MAXDIST = 3'd3,
        CFG_ATTEN   = 3'd4,
        CFG_ROLLOFF = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic        spatial;
        logic        beyond;
        logic        dx_le0;
        logic [23:0] adx;
        logic [23:0] ady;
        logic [47:0] sq_x;
        logic [47:0] sq_y;
        logic [49:0] sv;
        logic [49:0] sr;
        logic [22:0] t_rem;
        logic [15:0] t_q;
        logic        t_sat;
        logic [22:0] p_rem;
        logic [15:0] p_q;
        logic        p_sat;
        logic        t_zero;
        logic [4:0]  msb;
        logic [30:0] m;
        logic [15:0] frac;
        logic [20:0] lg;
        logic [24:0] y;
        logic [30:0] acc;
        logic [16:0] pan;
        logic [16:0] pw;
        logic [16:0] dg;
        logic [16:0] gain;
        logic [16:0] lgain;
        logic [16:0] rgain;
    } t_item;

    function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = '0;
        b   = 64'(1) << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q30, by repeated square roots from 0.5
    function automatic logic [29:0] exp_c(input int k);
        logic [63:0] c;
        c = isqrt_u64(64'(1) << 59);
        for (int j = 1; j < k; j++) begin
            c = isqrt_u64(c << 30);
        end
        return c[29:0];
    endfunction

    localparam logic [29:0] EXP_C [16] = '{
        exp_c(1),  exp_c(2),  exp_c(3),  exp_c(4),
        exp_c(5),  exp_c(6),  exp_c(7),  exp_c(8),
        exp_c(9),  exp_c(10), exp_c(11), exp_c(12),
        exp_c(13), exp_c(14), exp_c(15), exp_c(16)
    };

endpackage

`default_nettype wire

// File: hw/rtl/spatial_gain_pan_core.sv
`default_nettype none
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   sound_x/y, ear_x/y, sound_is_spatial
// output    out        o_out_valid / i_out_stall gain_l, gain_r, beyond_range
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; the depth is set by the 25-step square
// root, the 16-step dividers and the 16-step log2 and exp2 multiplier chains.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles close up and the input keeps flowing while a result waits.
// Reset clears the configuration to its defaults and empties the pipeline.
module spatial_gain_pan_core
    import sgp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [23:0] i_sound_x,
    input  wire logic [23:0] i_sound_y,
    input  wire logic [23:0] i_ear_x,
    input  wire logic [23:0] i_ear_y,
    input  wire logic        i_sound_is_spatial,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [16:0]      o_gain_l,
    output logic [16:0]      o_gain_r,
    output logic             o_beyond_range,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data
);

    logic        r_present;
    logic        r_wants;
    logic [6:0]  r_vol;
    logic [22:0] r_max;
    logic [16:0] r_att;
    logic [15:0] r_roll;
    logic [45:0] r_max_sq;
    logic [20:0] r_ref;
    logic [16:0] r_base;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_wants   <= 1'b0;
            r_vol     <= 7'd100;
            r_max     <= '0;
            r_att     <= GAIN_ONE;
            r_roll    <= 16'd4096;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PRESENT: r_present <= i_cfg_data[0];
                CFG_WANTS:   r_wants   <= i_cfg_data[0];
                CFG_VOLUME:  r_vol     <= (i_cfg_data[6:0] > 7'd100) ? 7'd100 : i_cfg_data[6:0];
                CFG_MAXDIST: r_max     <= i_cfg_data;
                CFG_ATTEN:   r_att     <= (i_cfg_data[16:0] > GAIN_ONE) ? GAIN_ONE
                                                                         : i_cfg_data[16:0];
                CFG_ROLLOFF: begin
                    if (i_cfg_data[15:0] < 16'd410) begin
                        r_roll <= 16'd410;
                    end else if (i_cfg_data[15:0] > 16'd32768) begin
                        r_roll <= 16'd32768;
                    end else begin
                        r_roll <= i_cfg_data[15:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // values derived from configuration, refreshed every cycle
    logic [42:0] w_base_prod;
    assign w_base_prod = {22'd0, r_vol, 14'd0} * 43'(BASE_RECIP);

    always_ff @(posedge i_clk) begin
        r_max_sq <= r_max * r_max;
        r_ref    <= (r_max[22:2] < 21'(1 << POS_FB)) ? 21'(1 << POS_FB) : r_max[22:2];
        r_base   <= r_present ? w_base_prod[42:26] : GAIN_ONE;
    end

    t_item r_pipe [N_STAGE];
    logic  r_vld  [N_STAGE];
    logic  w_en   [N_STAGE+1];

    assign w_en[N_STAGE] = !i_out_stall;
    assign o_in_stall    = !w_en[0];

    for (genvar k = 0; k < N_STAGE; k++) begin : g_stg
        t_item w_prev;
        t_item w_next;
        logic  w_vin;

        assign w_en[k] = !r_vld[k] || w_en[k+1];

        if (k == 0) begin : g_src
            assign w_vin  = i_in_valid;
            assign w_prev = '0;
        end else begin : g_chain
            assign w_vin  = r_vld[k-1];
            assign w_prev = r_pipe[k-1];
        end

        if (k == ST_DIFF) begin : g_diff
            logic signed [24:0] dx, dy;
            assign dx = $signed({i_sound_x[23], i_sound_x})
                      - $signed({i_ear_x[23], i_ear_x});
            assign dy = $signed({i_sound_y[23], i_sound_y})
                      - $signed({i_ear_y[23], i_ear_y});
            always_comb begin
                w_next         = w_prev;
                w_next.spatial = i_sound_is_spatial & r_present & r_wants & (r_max != '0);
                w_next.dx_le0  = dx[24] | (dx == '0);
                w_next.adx     = dx[24] ? 24'(-dx) : dx[23:0];
                w_next.ady     = dy[24] ? 24'(-dy) : dy[23:0];
            end
        end else if (k == ST_SQ) begin : g_sq
            always_comb begin
                w_next      = w_prev;
                w_next.sq_x = w_prev.adx * w_prev.adx;
                w_next.sq_y = w_prev.ady * w_prev.ady;
            end
        end else if (k == ST_SUM) begin : g_sum
            logic [48:0] d2;
            assign d2 = {1'b0, w_prev.sq_x} + {1'b0, w_prev.sq_y};
            always_comb begin
                w_next        = w_prev;
                w_next.beyond = d2 >= {3'd0, r_max_sq};
                w_next.sv     = {1'b0, d2};
                w_next.sr     = '0;
            end
        end else if (k >= ST_SQRT && k < ST_DIVI) begin : g_sqrt
            // one result bit per stage, digit pair weight 4^(24-i)
            localparam logic [49:0] BIT = 50'(1) << (2 * (SQRT_N - 1 - (k - ST_SQRT)));
            logic [49:0] trial;
            assign trial = w_prev.sr + BIT;
            always_comb begin
                w_next = w_prev;
                if (w_prev.sv >= trial) begin
                    w_next.sv = w_prev.sv - trial;
                    w_next.sr = (w_prev.sr >> 1) + BIT;
                end else begin
                    w_next.sr = w_prev.sr >> 1;
                end
            end
        end else if (k == ST_DIVI) begin : g_divi
            logic [24:0] num;
            assign num = {2'd0, r_max} - w_prev.sr[24:0];
            always_comb begin
                w_next       = w_prev;
                w_next.t_sat = num >= {2'd0, r_max};
                w_next.t_rem = num[22:0];
                w_next.t_q   = '0;
                w_next.p_sat = w_prev.adx >= {3'd0, r_ref};
                w_next.p_rem = w_prev.adx[22:0];
                w_next.p_q   = '0;
            end
        end else if (k >= ST_DIV && k < ST_LOGI) begin : g_div
            logic [23:0] tr, pr;
            assign tr = {w_prev.t_rem, 1'b0};
            assign pr = {w_prev.p_rem, 1'b0};
            always_comb begin
                w_next = w_prev;
                if (tr >= {1'b0, r_max}) begin
                    w_next.t_rem = 23'(tr - {1'b0, r_max});
                    w_next.t_q   = {w_prev.t_q[14:0], 1'b1};
                end else begin
                    w_next.t_rem = tr[22:0];
                    w_next.t_q   = {w_prev.t_q[14:0], 1'b0};
                end
                if (pr >= {3'd0, r_ref}) begin
                    w_next.p_rem = 23'(pr - {3'd0, r_ref});
                    w_next.p_q   = {w_prev.p_q[14:0], 1'b1};
                end else begin
                    w_next.p_rem = pr[22:0];
                    w_next.p_q   = {w_prev.p_q[14:0], 1'b0};
                end
            end
        end else if (k == ST_LOGI) begin : g_logi
            logic [16:0] t;
            logic [4:0]  msb;
            assign t = w_prev.t_sat ? GAIN_ONE : {1'b0, w_prev.t_q};
            always_comb begin
                msb = '0;
                for (int b = 1; b < 17; b++) begin
                    if (t[b]) msb = 5'(b);
                end
            end
            always_comb begin
                w_next        = w_prev;
                w_next.t_zero = (t == '0);
                w_next.msb    = msb;
                w_next.m      = 31'(t) << (5'd30 - msb);
                w_next.frac   = '0;
                w_next.pan    = w_prev.p_sat ? GAIN_ONE : {1'b0, w_prev.p_q};
            end
        end else if (k >= ST_LOG && k < ST_LOGF) begin : g_log
            localparam int FB = LOG_N - 1 - (k - ST_LOG);
            logic [61:0] sq;
            assign sq = w_prev.m * w_prev.m;
            always_comb begin
                w_next = w_prev;
                if (sq[61]) begin
                    w_next.m        = sq[61:31];
                    w_next.frac[FB] = 1'b1;
                end else begin
                    w_next.m = sq[60:30];
                end
            end
        end else if (k == ST_LOGF) begin : g_logf
            always_comb begin
                w_next    = w_prev;
                w_next.lg = {5'd16 - w_prev.msb, 16'd0} - {5'd0, w_prev.frac};
            end
        end else if (k == ST_POW) begin : g_pow
            logic [36:0] prod;
            assign prod = w_prev.lg * r_roll;
            always_comb begin
                w_next     = w_prev;
                w_next.y   = prod[36:12];
                w_next.acc = Q30_ONE;
            end
        end else if (k >= ST_EXP && k < ST_PW) begin : g_exp
            localparam int I = k - ST_EXP;
            logic [60:0] prod;
            assign prod = w_prev.acc * EXP_C[I];
            always_comb begin
                w_next = w_prev;
                if (w_prev.y[EXP_N - 1 - I]) begin
                    w_next.acc = prod[60:30];
                end
            end
        end else if (k == ST_PW) begin : g_pw
            logic [5:0]  sh;
            logic [30:0] full;
            assign sh   = 6'(w_prev.y[21:16]) + 6'd14;
            assign full = w_prev.acc >> sh;
            always_comb begin
                w_next = w_prev;
                if (w_prev.t_zero || (w_prev.y[24:16] > 9'd32)) begin
                    w_next.pw = '0;
                end else if (full > 31'(GAIN_ONE)) begin
                    w_next.pw = GAIN_ONE;
                end else begin
                    w_next.pw = full[16:0];
                end
            end
        end else if (k == ST_DG) begin : g_dg
            logic [33:0] ap;
            logic [34:0] s;
            assign ap = r_att * w_prev.pw;
            assign s  = {2'd0, GAIN_ONE - r_att, 16'd0} + {1'b0, ap};
            always_comb begin
                w_next    = w_prev;
                w_next.dg = (s[34:16] > 19'(GAIN_ONE)) ? GAIN_ONE : s[32:16];
            end
        end else if (k == ST_GAIN) begin : g_gain
            logic [33:0] prod;
            assign prod = r_base * w_prev.dg;
            always_comb begin
                w_next      = w_prev;
                w_next.gain = prod[32:16];
            end
        end else begin : g_out
            logic [16:0] ls, rs;
            logic [33:0] lp, rp;
            assign ls = w_prev.dx_le0 ? GAIN_ONE - w_prev.pan : GAIN_ONE;
            assign rs = w_prev.dx_le0 ? GAIN_ONE : GAIN_ONE - w_prev.pan;
            assign lp = w_prev.gain * ls;
            assign rp = w_prev.gain * rs;
            always_comb begin
                w_next        = w_prev;
                w_next.beyond = w_prev.spatial & w_prev.beyond;
                if (!w_prev.spatial) begin
                    w_next.lgain = r_base;
                    w_next.rgain = r_base;
                end else if (w_prev.beyond) begin
                    w_next.lgain = '0;
                    w_next.rgain = '0;
                end else begin
                    w_next.lgain = lp[32:16];
                    w_next.rgain = rp[32:16];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_vin;
            end
        end

        // hold while stalled
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_pipe[k] <= w_next;
            end
        end
    end

    assign o_out_valid    = r_vld[N_STAGE-1];
    assign o_gain_l       = r_pipe[N_STAGE-1].lgain;
    assign o_gain_r       = r_pipe[N_STAGE-1].rgain;
    assign o_beyond_range = r_pipe[N_STAGE-1].beyond;

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench
    import sgp_pkg::*;
();

    typedef struct {
        logic [23:0] sx;
        logic [23:0] sy;
        logic [23:0] lx;
        logic [23:0] ly;
        logic        sp;
    } t_pos_item;

    typedef struct {
        logic [16:0] left;
        logic [16:0] right;
        logic        beyond;
    } t_gains;

    localparam logic [2:0] CFG_UNUSED_IDX = 3'd6;
    localparam int RAND_PHASES = 13;
    localparam int PHASE_ITEMS = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [23:0] i_sound_x = '0;
    logic [23:0] i_sound_y = '0;
    logic [23:0] i_ear_x = '0;
    logic [23:0] i_ear_y = '0;
    logic        i_sound_is_spatial = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [22:0] i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [16:0] o_gain_l;
    logic [16:0] o_gain_r;
    logic        o_beyond_range;
    logic        o_cfg_ready;

    spatial_gain_pan_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // shadow configuration
    logic [63:0] sh_present = 0;
    logic [63:0] sh_wants = 0;
    logic [63:0] sh_volume = 100;
    logic [63:0] sh_maxdist = 0;
    logic [63:0] sh_atten = 65536;
    logic [63:0] sh_rolloff = 4096;

    t_pos_item pending_items[$];
    t_gains    expected_gains[$];
    int        mismatches = 0;
    bit        in_taken = 0;
    bit        quiet = 0;
    bit        rx_hold_req = 0;
    bit        rx_hold_done = 0;
    int        rx_hold_left = 0;
    int        tx_gap = 0;
    int        tx_run = 0;
    int        rx_burst = 0;
    int        rx_run = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] neg_log2_q16(input logic [63:0] t);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 0;
        frac = 0;
        while (p < 40 && (t >> (p + 1)) != 0) p++;
        m = t << (30 - p);
        for (int i = 1; i <= 16; i++) begin
            m = (m * m) >> 30;
            if (m >= (64'(1) << 31)) begin
                m = m >> 1;
                frac = frac | (64'(1) << (16 - i));
            end
        end
        return (64'(16 - p) << 16) - frac;
    endfunction

    function automatic logic [63:0] exp2_neg_q16(input logic [63:0] y);
        logic [63:0] ip;
        logic [63:0] f;
        logic [63:0] acc;
        logic [63:0] c;
        ip = y >> 16;
        f = y & 64'hFFFF;
        acc = 64'(1) << 30;
        if (ip > 32) return 0;
        c = int_sqrt(64'(1) << 59);
        for (int k = 1; k <= 16; k++) begin
            if ((f >> (16 - k)) & 1) acc = (acc * c) >> 30;
            c = int_sqrt(c << 30);
        end
        return acc >> (14 + ip);
    endfunction

    function automatic t_gains predict_gains(input t_pos_item it);
        t_gains      g;
        longint      dx;
        longint      dy;
        logic [63:0] one;
        logic [63:0] base;
        logic [63:0] left;
        logic [63:0] right;
        logic [63:0] adx;
        logic [63:0] ady;
        logic [63:0] d2;
        logic [63:0] d;
        logic [63:0] t;
        logic [63:0] pw;
        logic [63:0] dg;
        logic [63:0] gain;
        logic [63:0] pan_ref;
        logic [63:0] pan;
        logic [63:0] ls;
        logic [63:0] rs;
        one = 64'(1) << 16;
        base = sh_present ? (sh_volume * one) / 100 : one;
        left = base;
        right = base;
        g.beyond = 1'b0;
        if (it.sp && sh_present && sh_wants && sh_maxdist > 0) begin
            dx = longint'($signed(it.sx)) - longint'($signed(it.lx));
            dy = longint'($signed(it.sy)) - longint'($signed(it.ly));
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            d2 = adx * adx + ady * ady;
            if (d2 >= sh_maxdist * sh_maxdist) begin
                left = 0;
                right = 0;
                g.beyond = 1'b1;
            end else begin
                d = int_sqrt(d2);
                t = ((sh_maxdist - d) << 16) / sh_maxdist;
                pw = 0;
                if (t != 0) pw = exp2_neg_q16((neg_log2_q16(t) * sh_rolloff) >> 12);
                if (pw > one) pw = one;
                dg = ((one - sh_atten) * one + sh_atten * pw) >> 16;
                if (dg > one) dg = one;
                gain = (base * dg) >> 16;
                pan_ref = sh_maxdist >> 2;
                if (pan_ref < 256) pan_ref = 256;
                pan = (adx << 16) / pan_ref;
                if (pan > one) pan = one;
                ls = one;
                rs = one;
                if (dx <= 0) ls = one - pan;
                else rs = one - pan;
                left = (gain * ls) >> 16;
                right = (gain * rs) >> 16;
            end
        end
        g.left = left[16:0];
        g.right = right[16:0];
        return g;
    endfunction

    // sender: hold a stalled transfer, else advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            in_taken = 0;
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet && tx_run == 0 && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(1, 18) - 1;
                i_in_valid <= 1'b0;
            end else begin
                t_pos_item it;
                it = pending_items.pop_front();
                if (tx_run > 0) tx_run--;
                else if ($urandom_range(0, 3) == 0) tx_run = $urandom_range(10, 60);
                i_sound_x <= it.sx;
                i_sound_y <= it.sy;
                i_ear_x <= it.lx;
                i_ear_y <= it.ly;
                i_sound_is_spatial <= it.sp;
                i_in_valid <= 1'b1;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_done) begin
            rx_hold_done = 1;
            rx_hold_left = 400;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_out_stall <= 1'b1;
        end else if (rx_run > 0) begin
            rx_run--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 1) == 0) begin
            rx_burst = $urandom_range(1, 18) - 1;
            i_out_stall <= 1'b1;
        end else begin
            rx_run = $urandom_range(1, 40);
            i_out_stall <= 1'b0;
        end
    end

    // monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                t_pos_item it;
                it.sx = i_sound_x;
                it.sy = i_sound_y;
                it.lx = i_ear_x;
                it.ly = i_ear_y;
                it.sp = i_sound_is_spatial;
                expected_gains.push_back(predict_gains(it));
                in_taken = 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_gains.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result L=%0d R=%0d B=%0d",
                                 o_gain_l, o_gain_r, o_beyond_range);
                end else begin
                    t_gains e;
                    e = expected_gains.pop_front();
                    if (e.left !== o_gain_l || e.right !== o_gain_r ||
                        e.beyond !== o_beyond_range) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp L=%0d R=%0d B=%0d got L=%0d R=%0d B=%0d",
                                     e.left, e.right, e.beyond,
                                     o_gain_l, o_gain_r, o_beyond_range);
                    end
                end
            end
        end
    end

    // call just after a falling edge; leaves i_cfg_valid high
    task automatic cfg_write(input logic [2:0] idx, input logic [22:0] val);
        logic [63:0] v;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        v = 64'(val);
        case (idx)
            CFG_PRESENT: sh_present = v & 1;
            CFG_WANTS:   sh_wants = v & 1;
            CFG_VOLUME: begin
                v = v & 64'h7F;
                sh_volume = v > 100 ? 100 : v;
            end
            CFG_MAXDIST: sh_maxdist = v & 64'h7FFFFF;
            CFG_ATTEN: begin
                v = v & 64'h1FFFF;
                sh_atten = v > 65536 ? 65536 : v;
            end
            CFG_ROLLOFF: begin
                v = v & 64'hFFFF;
                if (v < 410) v = 410;
                if (v > 32768) v = 32768;
                sh_rolloff = v;
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic p, input logic w, input logic [22:0] vol,
                              input logic [22:0] md, input logic [22:0] at,
                              input logic [22:0] ro);
        cfg_write(CFG_PRESENT, 23'(p));
        cfg_write(CFG_WANTS, 23'(w));
        cfg_write(CFG_VOLUME, vol);
        cfg_write(CFG_MAXDIST, md);
        cfg_write(CFG_ATTEN, at);
        cfg_write(CFG_ROLLOFF, ro);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_gains.size() != 0)
            @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    function automatic t_pos_item offset_item(input logic [23:0] lx, input logic [23:0] ly,
                                              input longint dx, input longint dy,
                                              input logic sp);
        t_pos_item it;
        it.lx = lx;
        it.ly = ly;
        it.sx = 24'(longint'($signed(lx)) + dx);
        it.sy = 24'(longint'($signed(ly)) + dy);
        it.sp = sp;
        return it;
    endfunction

    function automatic t_pos_item random_item();
        t_pos_item   it;
        longint      r;
        longint      dx;
        longint      dy;
        logic [23:0] lx;
        logic [23:0] ly;
        if ($urandom_range(0, 9) < 3) begin
            it.sx = 24'($urandom());
            it.sy = 24'($urandom());
            it.lx = 24'($urandom());
            it.ly = 24'($urandom());
            it.sp = 1'($urandom());
            return it;
        end
        r = sh_maxdist + sh_maxdist / 4 + 4;
        if (r > 4000000) r = 4000000;
        dx = longint'($urandom_range(0, 32'(2 * r))) - r;
        dy = longint'($urandom_range(0, 32'(2 * r))) - r;
        case ($urandom_range(0, 7))
            0: dx = 0;
            1: dy = 0;
            default: ;
        endcase
        lx = 24'($signed(22'($urandom())));
        ly = 24'($signed(22'($urandom())));
        return offset_item(lx, ly, dx, dy, $urandom_range(0, 7) != 0);
    endfunction

    initial begin
        logic [22:0] md;
        logic [23:0] big;
        longint      mdl;
        longint      bigl;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no listener: base gain one, spatial path off
        pending_items.push_back(offset_item(24'h7FFFFF, 24'h800000, 0, 0, 1'b1));
        pending_items.push_back(offset_item(24'h000000, 24'h000000, 1000, -50, 1'b1));
        wait_drained();

        // out of range index is ignored
        cfg_write(CFG_UNUSED_IDX, 23'h7FFFFF);
        set_config(1'b1, 1'b1, 23'd100, 23'd25600, 23'd65536, 23'd4096);
        md = 23'd25600;
        mdl = longint'(md);
        pending_items.push_back(offset_item(24'd0, 24'd0, 0, 0, 1'b1));
        pending_items.push_back(offset_item(24'd0, 24'd0, mdl, 0, 1'b1));
        pending_items.push_back(offset_item(24'd0, 24'd0, -mdl, 0, 1'b1));
        pending_items.push_back(offset_item(24'd0, 24'd0, mdl - 1, 0, 1'b1));
        pending_items.push_back(offset_item(24'd0, 24'd0, 0, mdl - 1, 1'b1));
        pending_items.push_back(offset_item(24'd100, 24'd9, mdl / 2, 3, 1'b1));
        pending_items.push_back(offset_item(24'd100, 24'd9, -mdl / 2, -3, 1'b1));
        pending_items.push_back(offset_item(24'd5, 24'd5, mdl / 8, mdl / 8, 1'b1));
        pending_items.push_back(offset_item(24'd5, 24'd5, mdl / 8, mdl / 8, 1'b0));
        pending_items.push_back(offset_item(24'h7FFFFF, 24'h7FFFFF, -1, 0, 1'b1));
        pending_items.push_back(offset_item(24'h800000, 24'h800000, 1, 1, 1'b1));
        pending_items.push_back(offset_item(24'h800000, 24'h7FFFFF, 0, 0, 1'b1));
        wait_drained();

        // largest radius: a sound just inside gives a zero distance curve
        big = 24'd8388607;
        bigl = longint'(big);
        set_config(1'b1, 1'b1, 23'd127, 23'h7FFFFF, 23'd131071, 23'd0);
        pending_items.push_back(offset_item(24'h800000, 24'd0, bigl - 1, 0, 1'b1));
        pending_items.push_back(offset_item(24'h800000, 24'd0, bigl, 0, 1'b1));
        pending_items.push_back(offset_item(24'h800000, 24'h800000, bigl, bigl, 1'b1));
        pending_items.push_back(offset_item(24'd0, 24'd0, -4000, 700, 1'b1));
        wait_drained();

        // smallest radius, zero radius, listener not spatial
        set_config(1'b1, 1'b1, 23'd0, 23'd1, 23'd0, 23'd65535);
        pending_items.push_back(offset_item(24'd0, 24'd0, 0, 0, 1'b1));
        pending_items.push_back(offset_item(24'd0, 24'd0, 1, 0, 1'b1));
        wait_drained();
        set_config(1'b1, 1'b1, 23'd37, 23'd0, 23'd30000, 23'd32768);
        pending_items.push_back(offset_item(24'd0, 24'd0, 10, 0, 1'b1));
        wait_drained();
        set_config(1'b1, 1'b0, 23'd64, 23'd5000, 23'd30000, 23'd410);
        pending_items.push_back(offset_item(24'd0, 24'd0, 10, 0, 1'b1));
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: md = 23'($urandom_range(1, 255));
                1: md = 23'($urandom_range(256, 8192));
                2: md = 23'($urandom_range(8192, 1 << 20));
                3: md = 23'h7FFFFF;
                default: md = 23'($urandom());
            endcase
            if (ph == 0) md = 23'd1;
            set_config($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                       ph == 1 ? 23'd0 : 23'($urandom_range(0, 127)), md,
                       ph == 2 ? 23'd0 : 23'($urandom_range(0, 70000)),
                       ph == 3 ? 23'd32768 : 23'($urandom_range(0, 40000)));
            if (ph == RAND_PHASES - 2) quiet = 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item());
            // long receiver hold so the pipeline backs up to the input
            if (ph == 4) rx_hold_req = 1;
            wait_drained();
        end

        repeat (200) @(negedge i_clk);
        if (mismatches == 0 && expected_gains.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
